// ===== rtl/glqr_pkg.sv =====
// shared types, constants and helpers of the gain scheduled balance law
package glqr_pkg;

  localparam int STATE_COUNT = 6;
  localparam int ROW_COUNT = 2 * STATE_COUNT;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam logic [2:0] REG_INVERSE_PERIOD = 3'd0;
  localparam logic [2:0] REG_TICK_SECONDS = 3'd1;
  localparam logic [2:0] REG_WHEEL_RADIUS = 3'd2;
  localparam logic [2:0] REG_POSITION_LIMIT = 3'd3;
  localparam logic [2:0] REG_TILT_SETPOINT = 3'd4;

  // cubic coefficients in q16.16, degree 3 down to degree 0
  localparam logic signed [31:0] BASE_COEFF [12][4] = '{
    '{-32'sd258602611, 32'sd90856300, -32'sd19882152, -32'sd644988},
    '{32'sd12177218, -32'sd3110370, -32'sd718480, -32'sd230045},
    '{32'sd140873262, -32'sd35939812, 32'sd2724177, -32'sd615413},
    '{32'sd386501887, -32'sd102920470, 32'sd9706357, -32'sd788533},
    '{-32'sd176239274, 32'sd54630487, -32'sd10455324, 32'sd2285088},
    '{-32'sd106399788, 32'sd29840573, -32'sd3657904, 32'sd433523},
    '{32'sd571321062, -32'sd174027132, 32'sd20258022, 32'sd374810},
    '{32'sd14049117, -32'sd3554569, 32'sd77678, 32'sd241236},
    '{32'sd286903346, -32'sd73657569, 32'sd5605039, 32'sd276235},
    '{32'sd34295000, -32'sd2748922, -32'sd1511826, 32'sd444912},
    '{-32'sd50614709, -32'sd3353493, 32'sd5933998, 32'sd1975349},
    '{32'sd488769, -32'sd3726747, 32'sd1399660, 32'sd147065}
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LIN_M,
    ST_LIN_P,
    ST_RATE_M,
    ST_RATE_P,
    ST_POS_M,
    ST_POS_P,
    ST_GAIN_INIT,
    ST_HORN_M,
    ST_HORN_P,
    ST_TERM_M,
    ST_TERM_P,
    ST_EMIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/gain_scheduled_lqr_balance.sv =====
// gain scheduled lqr balance law: per tick errors times scheduled gains
// usage:
//   one input request on s_t* per control tick carries both legs' lengths,
//   hip angles, wheel and fused speeds, pitch, pitch rate and target speed;
//   off_ground travels in s_tuser. each tick gives four results on m_t*:
//   left wheel, left joint, right wheel, right joint; m_tuser holds leg and
//   actuator and m_tlast marks the fourth. registers are written over apb.
// timing:
//   one shared 34x34 multiplier with a registered product does all work, and a
//   new tick is taken once the last result of the previous one is loaded.
//   previous tilt and position live in two small synchronous memories read
//   once and written once per leg.
// reset clears the sequencer, the memories' valid bits (so they read zero)
// and the registers to their defaults. when m_tready is low the result
// register holds and the sequencer waits before loading the next result.
module gain_scheduled_lqr_balance #(
  parameter int POLY_TERMS = 4,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // leg_length_left[17:0], leg_length_right[35:18], hip_angle_left[55:36],
  // hip_angle_right[75:56], body_pitch[95:76], pitch_rate[127:96],
  // wheel_speed_left[159:128], wheel_speed_right[191:160],
  // fused_speed_left[223:192], fused_speed_right[255:224], target_speed[287:256]
  input  logic [287:0] s_tdata,
  // off_ground[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // term_tilt[31:0], term_tilt_rate[63:32], term_position[95:64],
  // term_speed[127:96], term_pitch[159:128], term_pitch_rate[191:160]
  output logic [191:0] m_tdata,
  // leg[0], actuator[1]
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int KW = (POLY_TERMS > 1) ? $clog2(POLY_TERMS) : 1;
  localparam longint HALF_PI =
    (glqr_pkg::HALF_PI_Q30 + (64'sd1 <<< (30 - FRACTION_BITS - 1))) >>>
    (30 - FRACTION_BITS);

  // registers
  logic [13:0]        inverse_period;
  logic [16:0]        tick_seconds;
  logic [16:0]        wheel_radius;
  logic [16:0]        position_limit;
  logic signed [18:0] tilt_setpoint;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_period <= 14'd500;
      tick_seconds <= 17'd131;
      wheel_radius <= 17'd3932;
      position_limit <= 17'd3277;
      tilt_setpoint <= 19'sd3431;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        glqr_pkg::REG_INVERSE_PERIOD: inverse_period <= pwdata[13:0];
        glqr_pkg::REG_TICK_SECONDS: tick_seconds <= pwdata[16:0];
        glqr_pkg::REG_WHEEL_RADIUS: wheel_radius <= pwdata[16:0];
        glqr_pkg::REG_POSITION_LIMIT: position_limit <= pwdata[16:0];
        glqr_pkg::REG_TILT_SETPOINT: tilt_setpoint <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      glqr_pkg::REG_INVERSE_PERIOD: prdata = {18'd0, inverse_period};
      glqr_pkg::REG_TICK_SECONDS: prdata = {15'd0, tick_seconds};
      glqr_pkg::REG_WHEEL_RADIUS: prdata = {15'd0, wheel_radius};
      glqr_pkg::REG_POSITION_LIMIT: prdata = {15'd0, position_limit};
      glqr_pkg::REG_TILT_SETPOINT: prdata = {{13{tilt_setpoint[18]}}, tilt_setpoint};
      default: prdata = 32'd0;
    endcase
  end

  // captured request
  logic [287:0] in_data;
  logic         in_off;

  // sequencer
  glqr_pkg::state_t state, state_next;
  logic          leg, act;
  logic [2:0]    idx;
  logic [KW-1:0] k;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [31:0] raw_sat, rnd_sat;
  logic signed [67:0] rnd_full;

  logic signed [31:0] err [6];
  logic signed [31:0] term [6];
  logic signed [31:0] acc;
  logic signed [31:0] lin;

  // state memories
  logic signed [31:0] tilt_mem [2];
  logic signed [31:0] pos_mem [2];
  logic [1:0]         mem_valid;
  logic signed [31:0] prev_tilt, prev_pos;

  // field views
  logic [17:0]        len_sel;
  logic signed [19:0] hip_sel, pitch;
  logic signed [31:0] pitch_rate, ws_sel, fs_sel, target;
  logic               moving;
  logic signed [31:0] tilt;
  logic [15:0]        s_arg;
  logic [3:0]         row;
  logic signed [31:0] pos_sum, pos_new;
  logic signed [31:0] lin_v, speed;

  assign len_sel = leg ? in_data[35:18] : in_data[17:0];
  assign hip_sel = leg ? in_data[75:56] : in_data[55:36];
  assign pitch = in_data[95:76];
  assign pitch_rate = in_data[127:96];
  assign ws_sel = leg ? in_data[191:160] : in_data[159:128];
  assign fs_sel = leg ? in_data[255:224] : in_data[223:192];
  assign target = in_data[287:256];
  assign moving = (target != 32'sd0);
  assign s_arg = len_sel[17:2];
  assign row = act ? ({1'b0, idx} + 4'd6) : {1'b0, idx};
  assign tilt = glqr_pkg::sat32(68'(hip_sel) - 68'(HALF_PI) - 68'(pitch));

  function automatic logic signed [31:0] coef(input logic [3:0] r, input logic [KW-1:0] kk);
    int deg;
    logic signed [63:0] c;
    logic signed [63:0] v;
    deg = POLY_TERMS - 1 - int'(kk);
    c = 64'sd0;
    if (deg <= 3 && r < 4'(glqr_pkg::ROW_COUNT))
      c = 64'(glqr_pkg::BASE_COEFF[r][3 - deg]);
    if (FRACTION_BITS > 16) v = c <<< (FRACTION_BITS - 16);
    else if (FRACTION_BITS < 16) v = (c + (64'sd1 <<< (15 - FRACTION_BITS))) >>>
                                     (16 - FRACTION_BITS);
    else v = c;
    return glqr_pkg::sat32(68'(v));
  endfunction

  // multiplier operand select
  always_comb begin
    ma = 34'sd0;
    mb = 34'sd0;
    case (state)
      glqr_pkg::ST_LIN_M: begin
        ma = 34'(ws_sel);
        mb = $signed({17'd0, wheel_radius});
      end
      glqr_pkg::ST_RATE_M: begin
        ma = 34'(tilt) - 34'(prev_tilt);
        mb = $signed({20'd0, inverse_period});
      end
      glqr_pkg::ST_POS_M: begin
        ma = $signed({17'd0, tick_seconds});
        mb = 34'(lin);
      end
      glqr_pkg::ST_HORN_M: begin
        ma = 34'(acc);
        mb = $signed({18'd0, s_arg});
      end
      glqr_pkg::ST_TERM_M: begin
        ma = 34'(err[idx]);
        mb = 34'(acc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  assign rnd_full = (prod + (68'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
  assign rnd_sat = glqr_pkg::sat32(rnd_full);
  assign raw_sat = glqr_pkg::sat32(prod);

  assign lin_v = leg ? glqr_pkg::sat32(-68'(rnd_sat)) : rnd_sat;
  assign speed = moving ? fs_sel : lin_v;
  assign pos_sum = glqr_pkg::sat32(68'(prev_pos) + 68'(rnd_sat));

  always_comb begin
    if (moving || in_off) pos_new = 32'sd0;
    else if (pos_sum > $signed({15'd0, position_limit})) pos_new = {15'd0, position_limit};
    else if (pos_sum < -$signed({15'd0, position_limit}))
      pos_new = -$signed({15'd0, position_limit});
    else pos_new = pos_sum;
  end

  always_comb begin
    state_next = state;
    case (state)
      glqr_pkg::ST_IDLE: if (s_tvalid) state_next = glqr_pkg::ST_LOAD;
      glqr_pkg::ST_LOAD: state_next = glqr_pkg::ST_LIN_M;
      glqr_pkg::ST_LIN_M: state_next = glqr_pkg::ST_LIN_P;
      glqr_pkg::ST_LIN_P: state_next = glqr_pkg::ST_RATE_M;
      glqr_pkg::ST_RATE_M: state_next = glqr_pkg::ST_RATE_P;
      glqr_pkg::ST_RATE_P: state_next = glqr_pkg::ST_POS_M;
      glqr_pkg::ST_POS_M: state_next = glqr_pkg::ST_POS_P;
      glqr_pkg::ST_POS_P: state_next = glqr_pkg::ST_GAIN_INIT;
      glqr_pkg::ST_GAIN_INIT: state_next = glqr_pkg::ST_HORN_M;
      glqr_pkg::ST_HORN_M: state_next = glqr_pkg::ST_HORN_P;
      glqr_pkg::ST_HORN_P:
        state_next = (k == KW'(POLY_TERMS - 1)) ? glqr_pkg::ST_TERM_M : glqr_pkg::ST_HORN_M;
      glqr_pkg::ST_TERM_M: state_next = glqr_pkg::ST_TERM_P;
      glqr_pkg::ST_TERM_P:
        state_next = (idx == 3'd5) ? glqr_pkg::ST_EMIT : glqr_pkg::ST_GAIN_INIT;
      glqr_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          if (!act) state_next = glqr_pkg::ST_GAIN_INIT;
          else if (!leg) state_next = glqr_pkg::ST_LOAD;
          else state_next = glqr_pkg::ST_IDLE;
        end
      end
      default: state_next = glqr_pkg::ST_IDLE;
    endcase
  end

  assign s_tready = (state == glqr_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= glqr_pkg::ST_IDLE;
    else state <= state_next;
  end

  // memories
  always_ff @(posedge clk) begin
    if (state == glqr_pkg::ST_LOAD) begin
      prev_tilt <= mem_valid[leg] ? tilt_mem[leg] : 32'sd0;
      prev_pos <= mem_valid[leg] ? pos_mem[leg] : 32'sd0;
    end
    if (state == glqr_pkg::ST_POS_P) begin
      tilt_mem[leg] <= tilt;
      pos_mem[leg] <= pos_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) mem_valid <= 2'b00;
    else if (state == glqr_pkg::ST_POS_P) mem_valid[leg] <= 1'b1;
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      leg <= 1'b0;
      act <= 1'b0;
      idx <= 3'd0;
      k <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != glqr_pkg::ST_EMIT) m_tvalid <= 1'b0;
      case (state)
        glqr_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            in_data <= s_tdata;
            in_off <= s_tuser;
            leg <= 1'b0;
            act <= 1'b0;
            idx <= 3'd0;
          end
        end
        glqr_pkg::ST_LIN_P: begin
          lin <= lin_v;
          err[3] <= glqr_pkg::sat32(68'(speed) - 68'(target));
          err[4] <= 32'(pitch);
          err[5] <= pitch_rate;
        end
        glqr_pkg::ST_RATE_P: begin
          err[0] <= glqr_pkg::sat32(68'(tilt) - 68'(tilt_setpoint));
          err[1] <= raw_sat;
        end
        glqr_pkg::ST_POS_P: err[2] <= pos_new;
        glqr_pkg::ST_GAIN_INIT: begin
          acc <= coef(row, '0);
          k <= KW'(1);
        end
        glqr_pkg::ST_HORN_P: begin
          acc <= glqr_pkg::sat32(68'(rnd_sat) + 68'(coef(row, k)));
          k <= k + KW'(1);
        end
        glqr_pkg::ST_TERM_P: begin
          term[idx] <= rnd_sat;
          idx <= idx + 3'd1;
        end
        glqr_pkg::ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {term[5], term[4], term[3], term[2], term[1], term[0]};
            m_tuser <= {act, leg};
            m_tlast <= act & leg;
            idx <= 3'd0;
            if (!act) act <= 1'b1;
            else begin
              act <= 1'b0;
              leg <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while a tick is in progress");

  a_last_is_right_joint: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == 2'b11))
    else $error("last flag on a result other than right joint");

  a_position_in_limit: assert property (@(posedge clk) disable iff (rst)
    (state == glqr_pkg::ST_POS_P) |->
      (pos_new <= $signed({15'd0, position_limit}) &&
       pos_new >= -$signed({15'd0, position_limit})))
    else $error("position written outside its clamp");
`endif

endmodule
